/* rtl/core/ile_pkg.sv */
// Package with the command codes, beat types and size defaults of the list engine.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int POS_W         = 8;
  localparam int COUNT_W       = 9;
  localparam int DATA_W        = 32;

  localparam logic [2:0] CMD_APPEND      = 3'd0;
  localparam logic [2:0] CMD_INSERT      = 3'd1;
  localparam logic [2:0] CMD_REMOVE_LAST = 3'd2;
  localparam logic [2:0] CMD_REMOVE_AT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR       = 3'd4;
  localparam logic [2:0] CMD_GET         = 3'd5;
  localparam logic [2:0] CMD_SET         = 3'd6;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     status;
  } rsp_t;

endpackage

/* rtl/core/indexed_list_engine_core.sv */
// Bounded ordered list of signed words with one memory and a shift sequencer.
// Append, remove last, clear, get and set go from the command beat straight to the finish
// state; insert and remove at, when entries must move, shift them one read and write pair
// per entry through the read and write states, and insert then writes the new value.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset clears the entry count and the sequencer; the entry memory is not cleared.
`timescale 1ns / 1ps

module indexed_list_engine_core #(
  parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ile_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ile_pkg::rsp_t rsp
);
  import ile_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SH_RD  = 5'b00010,
    S_SH_WR  = 5'b00100,
    S_INS_WR = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [XW-1:0]     lim, lim_next;
  logic              ins, ins_next;
  logic              st, st_next;
  logic              hit, hit_next;
  logic [DATA_W-1:0] val, val_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  logic [XW-1:0] cnt_x, pos_x, step_x;
  logic          full, empty, accept, out_free;

  assign cnt_x    = XW'(cnt);
  assign pos_x    = XW'(cmd.position);
  assign full     = (cnt_x == XW'(DEPTH));
  assign empty    = (cnt == '0);
  assign cmd_stall = (state != S_IDLE);
  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // Shared step unit: the neighbor index in the shift direction.
  assign step_x = ins ? (XW'(ptr) - XW'(1)) : (XW'(ptr) + XW'(1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ptr_next   = ptr;
    lim_next   = lim;
    ins_next   = ins;
    st_next    = st;
    hit_next   = hit;
    val_next   = val;
    we         = 1'b0;
    waddr      = ptr;
    wdata      = rdata;
    re         = 1'b0;
    raddr      = step_x[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          st_next    = 1'b0;
          hit_next   = 1'b0;
          val_next   = cmd.value;
          state_next = S_FINISH;
          case (cmd.command)
            CMD_APPEND: begin
              if (full) begin
                st_next = 1'b1;
              end else begin
                we       = 1'b1;
                waddr    = cnt_x[AW-1:0];
                wdata    = cmd.value;
                cnt_next = CW'(cnt_x + XW'(1));
              end
            end
            CMD_INSERT: begin
              if (full || pos_x > cnt_x) begin
                st_next = 1'b1;
              end else if (pos_x == cnt_x) begin
                we       = 1'b1;
                waddr    = pos_x[AW-1:0];
                wdata    = cmd.value;
                cnt_next = CW'(cnt_x + XW'(1));
              end else begin
                ins_next   = 1'b1;
                ptr_next   = cnt_x[AW-1:0];
                lim_next   = pos_x;
                state_next = S_SH_RD;
              end
            end
            CMD_REMOVE_LAST: begin
              if (empty) begin
                st_next = 1'b1;
              end else begin
                cnt_next = CW'(cnt_x - XW'(1));
              end
            end
            CMD_REMOVE_AT: begin
              if (empty) begin
                st_next = 1'b1;
              end else if (pos_x < cnt_x - XW'(1)) begin
                ins_next   = 1'b0;
                ptr_next   = pos_x[AW-1:0];
                lim_next   = cnt_x - XW'(1);
                state_next = S_SH_RD;
              end else begin
                cnt_next = CW'(cnt_x - XW'(1));
              end
            end
            CMD_CLEAR: begin
              cnt_next = '0;
            end
            CMD_GET: begin
              if (pos_x < cnt_x) begin
                re       = 1'b1;
                raddr    = pos_x[AW-1:0];
                hit_next = 1'b1;
              end else begin
                st_next = 1'b1;
              end
            end
            CMD_SET: begin
              if (pos_x < cnt_x) begin
                we    = 1'b1;
                waddr = pos_x[AW-1:0];
                wdata = cmd.value;
              end else begin
                st_next = 1'b1;
              end
            end
            default: begin
              st_next = 1'b1;
            end
          endcase
        end
      end
      S_SH_RD: begin
        re         = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata;
        ptr_next = step_x[AW-1:0];
        if (step_x == lim) begin
          if (ins) begin
            state_next = S_INS_WR;
          end else begin
            cnt_next   = CW'(cnt_x - XW'(1));
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_INS_WR: begin
        we         = 1'b1;
        waddr      = lim[AW-1:0];
        wdata      = val;
        cnt_next   = CW'(cnt_x + XW'(1));
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    ptr <= ptr_next;
    lim <= lim_next;
    ins <= ins_next;
    st  <= st_next;
    hit <= hit_next;
    val <= val_next;
  end

  // The result beat is loaded from the finish state once the output slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (state == S_FINISH && out_free) begin
      rsp.read_value  <= hit ? rdata : '0;
      rsp.entry_count <= cnt_x[COUNT_W-1:0];
      rsp.status      <= st;
    end
  end

endmodule

/* dv/tb_indexed_list_engine_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list engine: directed edges, a full list, random mixes.

module tb_indexed_list_engine_core;
  import ile_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Slowest beat is a shift of the whole list, plus a full stall burst on either side.
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list, updated when a command beat is accepted.
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int unsigned list_len = 0;
  rsp_t expected_rsp[$];
  rsp_t want;
  int err_cnt = 0;
  int idle_odds = 0;
  int stall_left = 0;
  int unsigned cycle_cnt = 0;

  indexed_list_engine_core #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  function automatic rsp_t apply_list_cmd(input cmd_t c);
    rsp_t r;
    int unsigned p;
    r = '0;
    p = c.position;
    case (c.command)
      CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = 1'b1;
        end else begin
          list_mem[list_len] = c.value;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (list_len >= LIST_DEPTH || p > list_len) begin
          r.status = 1'b1;
        end else begin
          for (int unsigned i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p] = c.value;
          list_len++;
        end
      end
      CMD_REMOVE_LAST: begin
        if (list_len == 0) r.status = 1'b1;
        else list_len--;
      end
      CMD_REMOVE_AT: begin
        // A position past the end still counts as done and drops the last entry.
        if (list_len == 0) begin
          r.status = 1'b1;
        end else begin
          if (p < list_len) begin
            for (int unsigned i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          end
          list_len--;
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_GET: begin
        if (p < list_len) r.read_value = list_mem[p];
        else r.status = 1'b1;
      end
      CMD_SET: begin
        if (p < list_len) list_mem[p] = c.value;
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.entry_count = COUNT_W'(list_len);
    return r;
  endfunction

  // Random command that keeps the list short most of the time, so shifts stay cheap.
  function automatic cmd_t pick_list_cmd();
    cmd_t c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) c.command = CMD_APPEND;
    else if (roll < 40) c.command = CMD_INSERT;
    else if (roll < 50) c.command = CMD_REMOVE_LAST;
    else if (roll < 64) c.command = CMD_REMOVE_AT;
    else if (roll < 66) c.command = CMD_CLEAR;
    else if (roll < 83) c.command = CMD_GET;
    else if (roll < 97) c.command = CMD_SET;
    else c.command = CMD_UNUSED;
    if (list_len > 48 && (c.command == CMD_APPEND || c.command == CMD_INSERT) &&
        $urandom_range(0, 1) == 1) begin
      c.command = CMD_REMOVE_AT;
    end
    if ($urandom_range(0, 99) < 80) c.position = POS_W'($urandom_range(0, list_len));
    else c.position = POS_W'($urandom_range(0, 255));
    c.value = $urandom;
    return c;
  endfunction

  task automatic send_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] val);
    cmd_t c;
    c.command = op;
    c.position = pos;
    c.value = val;
    if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    expected_rsp.push_back(apply_list_cmd(c));
  endtask

  task automatic test_directed_edges();
    idle_odds = 20;
    send_cmd(CMD_REMOVE_LAST, 8'd0, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'd0, 32'd0);
    send_cmd(CMD_GET, 8'd0, 32'd0);
    send_cmd(CMD_SET, 8'd0, 32'd5);
    send_cmd(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_APPEND, 8'd0, 32'h7FFF_FFFF);
    send_cmd(CMD_APPEND, 8'hFF, 32'h8000_0000);
    send_cmd(CMD_INSERT, 8'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 8'd3, 32'd0);
    send_cmd(CMD_INSERT, 8'd5, 32'd1);
    send_cmd(CMD_INSERT, 8'hFF, 32'd2);
    send_cmd(CMD_GET, 8'd0, 32'd0);
    send_cmd(CMD_GET, 8'd1, 32'd0);
    send_cmd(CMD_GET, 8'd3, 32'd0);
    send_cmd(CMD_SET, 8'd1, 32'h5A5A_A5A5);
    send_cmd(CMD_GET, 8'd1, 32'd0);
    send_cmd(CMD_GET, 8'hFF, 32'd0);
    send_cmd(CMD_SET, 8'd4, 32'd9);
    send_cmd(CMD_REMOVE_AT, 8'hFF, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'd0, 32'd0);
    send_cmd(CMD_REMOVE_LAST, 8'd0, 32'd0);
    send_cmd(CMD_GET, 8'd0, 32'd0);
    send_cmd(CMD_CLEAR, 8'd0, 32'd0);
    send_cmd(CMD_GET, 8'd0, 32'd0);
    send_cmd(CMD_CLEAR, 8'd0, 32'd0);
  endtask

  task automatic test_full_list();
    idle_odds = 10;
    while (list_len < LIST_DEPTH) send_cmd(CMD_APPEND, POS_W'($urandom), $urandom);
    send_cmd(CMD_APPEND, 8'd0, $urandom);
    send_cmd(CMD_INSERT, 8'd0, $urandom);
    send_cmd(CMD_INSERT, 8'hFF, $urandom);
    send_cmd(CMD_GET, 8'hFF, 32'd0);
    send_cmd(CMD_SET, 8'hFF, $urandom);
    send_cmd(CMD_GET, 8'hFF, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'hFF, 32'd0);
    // With 255 entries, position 255 is out of range and drops the last entry.
    send_cmd(CMD_INSERT, 8'd0, $urandom);
    send_cmd(CMD_REMOVE_AT, 8'hFF, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'hFF, 32'd0);
    send_cmd(CMD_GET, 8'd0, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'd0, 32'd0);
    send_cmd(CMD_REMOVE_AT, 8'd100, 32'd0);
    send_cmd(CMD_INSERT, POS_W'(list_len), $urandom);
    send_cmd(CMD_GET, 8'd100, 32'd0);
    send_cmd(CMD_GET, POS_W'(list_len - 1), 32'd0);
    send_cmd(CMD_CLEAR, 8'd0, 32'd0);
  endtask

  task automatic test_random_mix(input int n_items);
    cmd_t c;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) idle_odds = ($urandom_range(0, 2) == 0) ? 0 : 30;
      c = pick_list_cmd();
      send_cmd(c.command, c.position, c.value);
    end
  endtask

  task automatic test_steady_tail(input int n_items);
    cmd_t c;
    idle_odds = 0;
    for (int k = 0; k < n_items; k++) begin
      c = pick_list_cmd();
      send_cmd(c.command, c.position, c.value);
    end
  endtask

  always @(posedge clk) begin
    if (rst || idle_odds == 0) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 99) < idle_odds / 4) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("result beat with no command outstanding: %p", rsp);
        err_cnt++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
          err_cnt++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
          err_cnt++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, rsp.status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_full_list();
    test_random_mix(520);
    test_steady_tail(100);
    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && expected_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ile_pkg.sv
rtl/core/indexed_list_engine_core.sv
dv/tb_indexed_list_engine_core.sv
